// File: sv/ghs_pkg.sv
// Shared types, constants and helpers for the gantry homing sequencer.
package ghs_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_Z_BACKOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BACKOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BACKOFF = 2'd2;

    localparam logic [CFG_W-1:0] RST_Z_BACKOFF = 16'd500;
    localparam logic [CFG_W-1:0] RST_Y_BACKOFF = 16'd5000;
    localparam logic [CFG_W-1:0] RST_X_BACKOFF = 16'd5000;

    localparam logic [2:0] AX_X = 3'b001;
    localparam logic [2:0] AX_Y = 3'b010;
    localparam logic [2:0] AX_Z = 3'b100;

    localparam logic [2:0] PC_JOG   = 3'd0;
    localparam logic [2:0] PC_Z_DN  = 3'd1;
    localparam logic [2:0] PC_Z_UP  = 3'd2;
    localparam logic [2:0] PC_Y_RT  = 3'd3;
    localparam logic [2:0] PC_Y_LT  = 3'd4;
    localparam logic [2:0] PC_X_BK  = 3'd5;
    localparam logic [2:0] PC_X_FW  = 3'd6;
    localparam logic [2:0] PC_DONE  = 3'd7;

    typedef enum logic [7:0] {
        PH_JOG  = 8'b0000_0001,
        PH_Z_DN = 8'b0000_0010,
        PH_Z_UP = 8'b0000_0100,
        PH_Y_RT = 8'b0000_1000,
        PH_Y_LT = 8'b0001_0000,
        PH_X_BK = 8'b0010_0000,
        PH_X_FW = 8'b0100_0000,
        PH_DONE = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic jog_left;
        logic jog_forward;
        logic jog_finish;
        logic z_sensor_edge;
        logic y_sensor_edge;
        logic x_sensor_edge;
    } t_item;

    typedef struct packed {
        logic       x_pulse_level;
        logic       x_direction;
        logic       y_pulse_level;
        logic       y_direction;
        logic       z_pulse_level;
        logic       z_direction;
        logic [2:0] current_phase;
        logic       homing_complete;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] c;
        case (ph)
            PH_JOG:  c = PC_JOG;
            PH_Z_DN: c = PC_Z_DN;
            PH_Z_UP: c = PC_Z_UP;
            PH_Y_RT: c = PC_Y_RT;
            PH_Y_LT: c = PC_Y_LT;
            PH_X_BK: c = PC_X_BK;
            PH_X_FW: c = PC_X_FW;
            default: c = PC_DONE;
        endcase
        return c;
    endfunction

endpackage

// File: sv/ghs_item_if.sv
// Valid/ready channel carrying one tick's button and sensor inputs.
interface ghs_item_if;
    import ghs_pkg::*;

    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/ghs_result_if.sv
// Valid/ready channel carrying one tick's axis outputs and phase.
interface ghs_result_if;
    import ghs_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/ghs_core.sv
// Homing phase sequencer state, back-off counter and config registers.
module ghs_core #(
    parameter int COUNT_BITS = ghs_pkg::COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ghs_pkg::t_item   i_item,
    input  ghs_pkg::t_cfg_wr i_cfg,
    output ghs_pkg::t_result o_result
);
    import ghs_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic [CFG_W-1:0]      r_z_bo, r_y_bo, r_x_bo;
    t_phase                r_phase, n_phase;
    logic [2:0]            r_run, n_run;
    logic [2:0]            r_lvl, n_lvl;
    logic [2:0]            r_dir, n_dir;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [2:0]            hold, tog, active;
    logic                  z_done, y_done, x_done, cnt_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_bo <= RST_Z_BACKOFF;
            r_y_bo <= RST_Y_BACKOFF;
            r_x_bo <= RST_X_BACKOFF;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_Z_BACKOFF: r_z_bo <= i_cfg.data;
                CFG_Y_BACKOFF: r_y_bo <= i_cfg.data;
                CFG_X_BACKOFF: r_x_bo <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // count never exceeds its max, so saturating the limit equals "at max"
    assign cnt_max = &r_cnt;
    assign z_done  = (CMP_W'(r_cnt) >= CMP_W'(r_z_bo)) || cnt_max;
    assign y_done  = (CMP_W'(r_cnt) >= CMP_W'(r_y_bo)) || cnt_max;
    assign x_done  = (CMP_W'(r_cnt) >= CMP_W'(r_x_bo)) || cnt_max;

    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_lvl   = r_lvl;
        n_dir   = r_dir;
        n_cnt   = r_cnt;
        hold    = 3'b000;
        active  = 3'b000;

        case (r_phase)
            PH_JOG: begin
                if (i_item.jog_finish) begin
                    n_run   = (n_run & ~(AX_X | AX_Y)) | AX_Z;
                    n_dir   = n_dir & ~AX_Z;
                    n_phase = PH_Z_DN;
                end else begin
                    if (i_item.jog_left) begin
                        n_dir = n_dir | AX_Y;
                        n_run = n_run | AX_Y;
                    end else begin
                        n_run = n_run & ~AX_Y;
                        n_lvl = n_lvl & ~AX_Y;
                    end
                    if (i_item.jog_forward) begin
                        n_dir = n_dir | AX_X;
                        n_run = n_run | AX_X;
                    end else begin
                        n_run = n_run & ~AX_X;
                        n_lvl = n_lvl & ~AX_X;
                    end
                end
            end
            PH_Z_DN: begin
                n_dir = n_dir & ~AX_Z;
                n_run = n_run | AX_Z;
                if (i_item.z_sensor_edge) begin
                    n_lvl   = n_lvl & ~AX_Z;
                    n_dir   = n_dir | AX_Z;
                    n_cnt   = '0;
                    hold    = AX_Z;
                    n_phase = PH_Z_UP;
                end
            end
            PH_Z_UP: begin
                if (z_done) begin
                    n_run   = (n_run & ~AX_Z) | AX_Y;
                    n_lvl   = n_lvl & ~AX_Z;
                    n_dir   = n_dir & ~AX_Y;
                    n_phase = PH_Y_RT;
                end
            end
            PH_Y_RT: begin
                n_dir = n_dir & ~AX_Y;
                n_run = n_run | AX_Y;
                if (i_item.y_sensor_edge) begin
                    n_lvl   = n_lvl & ~AX_Y;
                    n_dir   = n_dir | AX_Y;
                    n_cnt   = '0;
                    hold    = AX_Y;
                    n_phase = PH_Y_LT;
                end
            end
            PH_Y_LT: begin
                if (y_done) begin
                    n_run   = (n_run & ~AX_Y) | AX_X;
                    n_lvl   = n_lvl & ~AX_Y;
                    n_dir   = n_dir & ~AX_X;
                    n_phase = PH_X_BK;
                end
            end
            PH_X_BK: begin
                n_dir = n_dir & ~AX_X;
                n_run = n_run | AX_X;
                if (i_item.x_sensor_edge) begin
                    n_lvl   = n_lvl & ~AX_X;
                    n_dir   = n_dir | AX_X;
                    n_cnt   = '0;
                    hold    = AX_X;
                    n_phase = PH_X_FW;
                end
            end
            PH_X_FW: begin
                if (x_done) begin
                    n_run   = n_run & ~AX_X;
                    n_lvl   = n_lvl & ~AX_X;
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase

        tog   = n_run & ~hold;
        n_lvl = n_lvl ^ tog;

        case (n_phase)
            PH_Z_UP: active = AX_Z;
            PH_Y_LT: active = AX_Y;
            PH_X_FW: active = AX_X;
            default: active = 3'b000;
        endcase

        // pulses counted on rising level edges of the backing-off axis
        if (((tog & active) != 3'b000) && ((n_lvl & active) != 3'b000) && !(&n_cnt)) begin
            n_cnt = COUNT_BITS'(n_cnt + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_JOG;
            r_run   <= '0;
            r_lvl   <= '0;
            r_dir   <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_lvl   <= n_lvl;
            r_dir   <= n_dir;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_result.x_pulse_level   = n_lvl[0];
        o_result.x_direction     = n_dir[0];
        o_result.y_pulse_level   = n_lvl[1];
        o_result.y_direction     = n_dir[1];
        o_result.z_pulse_level   = n_lvl[2];
        o_result.z_direction     = n_dir[2];
        o_result.current_phase   = phase_code(n_phase);
        o_result.homing_complete = (n_phase == PH_DONE);
    end

endmodule

// File: sv/ghs_out_buf.sv
// Result register with a skid stage for output backpressure.
module ghs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ghs_pkg::t_result i_result,
    output logic             o_ready,
    ghs_result_if.source     o_result
);
    import ghs_pkg::*;

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    main_free;

    assign o_ready   = !r_skid_v;
    assign main_free = !r_main_v || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (main_free) begin
            r_main_v <= r_skid_v || i_valid;
            r_skid_v <= 1'b0;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_v ? r_skid : i_result;
        end else if (i_valid) begin
            r_skid <= i_result;
        end
    end

    assign o_result.valid   = r_main_v;
    assign o_result.payload = r_main;

endmodule

// File: sv/gantry_homing_sequencer.sv
// Top level of the gantry homing sequencer.
// The result of an accepted input transaction is registered in the output stage.
// Throughput: one transaction per cycle unless the output stalls; the phase and
// back-off counter update on each accept; a two-entry output stage absorbs stalls.
// Reset (synchronous, active low): jog phase, all axes stopped and low,
// counter zero, back-off registers at 500 / 5000 / 5000.
module gantry_homing_sequencer #(
    parameter int COUNT_BITS = ghs_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ghs_item_if.sink                      i_item,
    ghs_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [ghs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ghs_pkg::CFG_W-1:0]     i_cfg_data
);
    import ghs_pkg::*;

    logic    buf_ready;
    logic    accept;
    t_result core_result;
    t_cfg_wr cfg;

    assign i_item.ready = buf_ready;
    assign accept       = i_item.valid && buf_ready;
    assign cfg.we       = i_cfg_we;
    assign cfg.idx      = i_cfg_idx;
    assign cfg.data     = i_cfg_data;

    ghs_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item.payload),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    ghs_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_result (core_result),
        .o_ready  (buf_ready),
        .o_result (o_result)
    );

endmodule

// File: sv/ghs_checker.sv
// Port-level assertions for the gantry homing sequencer, with bind.
module ghs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input ghs_pkg::t_result i_result
);
    import ghs_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_result)))
        else $error("result changed or dropped while stalled");

    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_result.homing_complete == (i_result.current_phase == PC_DONE)))
        else $error("homing_complete disagrees with phase");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.current_phase == PC_DONE) |->
        (!i_result.x_pulse_level && !i_result.y_pulse_level && !i_result.z_pulse_level))
        else $error("axis pulsing after homing done");

    a_jog_z_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.current_phase == PC_JOG) |->
        (!i_result.z_pulse_level && !i_result.z_direction))
        else $error("Z active during jog");

    a_xback_y_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_result.current_phase == PC_X_BK) |->
        (!i_result.y_pulse_level && !i_result.x_direction))
        else $error("bad axis state while X seeks");

endmodule

bind gantry_homing_sequencer ghs_checker u_ghs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_result.valid),
    .i_ready  (o_result.ready),
    .i_result (o_result.payload)
);
